>>> hdl/awbm_pkg.sv
// ----------------------------------------------------------------------------
// awbm_pkg - shared types and constants for the amplicon window builder
// Request structs, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package awbm_pkg;

  localparam int POS_BITS    = 40;
  localparam int MAX_WINDOWS = 32;
  localparam int IDX_BITS    = $clog2(MAX_WINDOWS);
  localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
  localparam int LEN_BITS    = 6;
  localparam int REG_BITS    = 3;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [REG_BITS-1:0] {
    REG_ANC_LEN   = 3'd0,
    REG_MATE_LEN  = 3'd1,
    REG_REF_BASES = 3'd2,
    REG_AMP_MIN   = 3'd3,
    REG_AMP_MAX   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic hit_valid;
    pos_t hit_position;
    logic hit_reverse;
    logic last_hit;
  } hit_req_t;

  typedef struct packed {
    logic list_reverse_mate;
    pos_t window_begin;
    pos_t window_end;
    logic window_valid;
    logic overflow;
    logic last_window;
  } window_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6,
    ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6,
    ST_CHECK, ST_AFTER,
    ST_LIST, ST_RD, ST_CMP, ST_MERGE, ST_TAIL, ST_FINAL
  } state_t;

endpackage
`default_nettype wire

>>> hdl/amplicon_window_build_merge.sv
// ----------------------------------------------------------------------------
// amplicon_window_build_merge - mate start windows from anchor primer hits
// Builds at most one window per hit, then sorts, merges and reports both lists.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// hit       in         start & !busy         hit_req_t (valid, position, strand, last)
// result    out        done, one cycle       window_t
// cfg       in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// Each hit passes from its accepting edge through the shared 41-bit
// add/subtract unit and its comparator before the next can be taken; a hit
// with hit_valid low skips the unit.
// On last_hit each list of n windows is merged by selection: n scans of the
// window memory through its one read port, each entry read and then compared,
// and one final result is delivered after both lists.
// Synchronous reset restores the register defaults and empties both lists.
// Results leave one per done pulse; the receiver cannot stall them.
// cfg is always ready; writes are meant for an idle block.
`timescale 1ns / 1ps
`default_nettype none
module amplicon_window_build_merge (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire awbm_pkg::hit_req_t      hit,
  output logic                         done,
  output awbm_pkg::window_t            result,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [awbm_pkg::REG_BITS-1:0] cfg_index,
  input  wire [awbm_pkg::POS_BITS-1:0] cfg_data
);
  import awbm_pkg::*;

  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  // configuration registers
  logic [LEN_BITS-1:0] anc_len, mate_len;
  pos_t ref_bases, amp_min, amp_max;

  state_t state, state_next;
  hit_req_t req;

  // working registers of the window build
  pos_t lo, hi, top, dm, mm;

  // window memory: list bit on top of the entry index, {begin, end} per word
  logic [2*POS_BITS-1:0] mem [2*MAX_WINDOWS];
  logic [2*POS_BITS-1:0] rdata;
  logic                  we;
  logic [IDX_BITS:0]     waddr;

  logic [CNT_BITS-1:0] fwd_cnt, rev_cnt;
  logic                overflow_flag;

  // merge pass state
  logic                list;
  logic [IDX_BITS-1:0] idx, best_idx;
  logic [CNT_BITS-1:0] picked;
  logic [MAX_WINDOWS-1:0] used;
  logic                have_best;
  pos_t best_b, best_e, cb, ce;
  window_t pend;
  logic    pend_v;

  // shared arithmetic unit: one 41-bit add or subtract, one comparator
  pos_t          alu_a, alu_b, cmp_a, cmp_b;
  logic          alu_sub;
  logic [POS_BITS:0] alu_sum;
  logic          alu_c, cmp_lt;
  pos_t          alu_res, alu_sat;

  assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_c   = alu_sum[POS_BITS];
  assign alu_res = alu_sum[POS_BITS-1:0];
  assign alu_sat = alu_c ? (alu_sub ? '0 : POS_MAX) : alu_res;
  assign cmp_lt  = cmp_a < cmp_b;

  pos_t pos, al_x, ml_x;
  assign pos  = req.hit_position;
  assign al_x = {{(POS_BITS-LEN_BITS){1'b0}}, anc_len};
  assign ml_x = {{(POS_BITS-LEN_BITS){1'b0}}, mate_len};

  always_comb begin
    alu_a = pos; alu_b = al_x; alu_sub = 1'b0;
    cmp_a = lo;  cmp_b = alu_sat;
    case (state)
      ST_D1: begin alu_a = amp_max; alu_b = ml_x; alu_sub = 1'b1; end
      ST_D2, ST_U1: begin alu_a = ref_bases; alu_b = ml_x; alu_sub = 1'b1; end
      ST_D4: begin alu_a = amp_min; alu_b = ml_x; alu_sub = 1'b1; end
      ST_D5: begin alu_b = mm; end
      ST_D6: begin alu_b = dm; cmp_a = top; end
      ST_U2: begin alu_b = ml_x; alu_sub = 1'b1; end
      ST_U4: begin alu_a = mm; alu_b = amp_min; alu_sub = 1'b1; end
      ST_U5: begin alu_a = mm; alu_b = amp_max; alu_sub = 1'b1;
        cmp_a = dm; cmp_b = hi; end
      ST_U6: begin cmp_a = top; cmp_b = hi; end
      ST_CHECK: begin cmp_a = hi; cmp_b = lo; end
      default: ;
    endcase
  end

  // merge-side compares
  logic [CNT_BITS-1:0] n_cur;
  pos_t rd_b, rd_e, ce_inc;
  logic rd_less, join_ok;
  assign n_cur   = list ? rev_cnt : fwd_cnt;
  assign rd_b    = rdata[2*POS_BITS-1:POS_BITS];
  assign rd_e    = rdata[POS_BITS-1:0];
  assign rd_less = (rd_b < best_b) || ((rd_b == best_b) && (rd_e < best_e));
  assign ce_inc  = (ce == POS_MAX) ? ce : ce + 1'b1;
  assign join_ok = best_b <= ce_inc;

  logic last_scan, last_pick;
  assign last_scan = ({1'b0, idx} == n_cur - 1'b1);
  assign last_pick = (picked + 1'b1 == n_cur);

  logic wl;  // target list: reverse hit feeds the forward-mate list
  logic [CNT_BITS-1:0] w_cnt;
  assign wl    = ~req.hit_reverse;
  assign w_cnt = wl ? rev_cnt : fwd_cnt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) begin
        if (!hit.hit_valid) state_next = ST_AFTER;
        else if (hit.hit_reverse) state_next = ST_U1;
        else state_next = ST_D1;
      end
      ST_D1: state_next = alu_c ? ST_AFTER : ST_D2;
      ST_D2: state_next = alu_c ? ST_AFTER : ST_D3;
      ST_D3: state_next = ST_D4;
      ST_D4: state_next = (!alu_c && alu_res != '0) ? ST_D5 : ST_D6;
      ST_D5: state_next = ST_D6;
      ST_D6: state_next = ST_CHECK;
      ST_U1: state_next = alu_c ? ST_AFTER : ST_U2;
      ST_U2: state_next = alu_c ? ST_AFTER : ST_U3;
      ST_U3: state_next = ST_U4;
      ST_U4: state_next = alu_c ? ST_AFTER : ST_U5;
      ST_U5: state_next = ST_U6;
      ST_U6: state_next = ST_CHECK;
      ST_CHECK: state_next = ST_AFTER;
      ST_AFTER: state_next = req.last_hit ? ST_LIST : ST_IDLE;
      ST_LIST: begin
        if (n_cur != '0) state_next = ST_RD;
        else if (list) state_next = ST_FINAL;
      end
      ST_RD:    state_next = ST_CMP;
      ST_CMP:   state_next = last_scan ? ST_MERGE : ST_RD;
      ST_MERGE: state_next = last_pick ? ST_TAIL : ST_RD;
      ST_TAIL:  state_next = list ? ST_FINAL : ST_LIST;
      ST_FINAL: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // memory
  assign we    = (state == ST_CHECK) && !cmp_lt && (w_cnt < CNT_BITS'(MAX_WINDOWS));
  assign waddr = {wl, w_cnt[IDX_BITS-1:0]};
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {lo, hi};
    rdata <= mem[{list, idx}];
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      anc_len   <= LEN_BITS'(20);
      mate_len  <= LEN_BITS'(20);
      ref_bases <= '0;
      amp_min   <= POS_BITS'(1);
      amp_max   <= POS_BITS'(1000);
      fwd_cnt <= '0; rev_cnt <= '0; overflow_flag <= 1'b0;
      pend_v <= 1'b0; done <= 1'b0; have_best <= 1'b0;
      used <= '0; list <= 1'b0; idx <= '0; picked <= '0;
    end else begin
      // a result goes out when a run closes, at the list tail and at the end
      done <= ((state == ST_MERGE) && (picked != '0) && !join_ok && pend_v)
           || ((state == ST_TAIL) && pend_v) || (state == ST_FINAL);
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ANC_LEN:   anc_len   <= cfg_data[LEN_BITS-1:0];
          REG_MATE_LEN:  mate_len  <= cfg_data[LEN_BITS-1:0];
          REG_REF_BASES: ref_bases <= cfg_data;
          REG_AMP_MIN:   amp_min   <= cfg_data;
          REG_AMP_MAX:   amp_max   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (start) req <= hit;
        ST_D1: dm <= alu_res;
        ST_D2, ST_U1: top <= alu_res;
        ST_D3: lo <= alu_sat;
        ST_D4: mm <= alu_res;
        ST_D5: if (cmp_lt) lo <= alu_sat;
        ST_D6: hi <= cmp_lt ? top : alu_sat;
        ST_U2: dm <= alu_res;
        ST_U3: mm <= alu_sat;
        ST_U4: hi <= alu_res;
        ST_U5: begin lo <= alu_sat; if (cmp_lt) hi <= dm; end
        ST_U6: if (cmp_lt) hi <= top;
        ST_CHECK: if (!cmp_lt) begin
          if (w_cnt >= CNT_BITS'(MAX_WINDOWS)) overflow_flag <= 1'b1;
          else if (wl) rev_cnt <= rev_cnt + 1'b1;
          else fwd_cnt <= fwd_cnt + 1'b1;
        end
        ST_AFTER: list <= 1'b0;
        ST_LIST: begin
          used <= '0; picked <= '0; idx <= '0; have_best <= 1'b0;
          if (n_cur == '0) list <= 1'b1;
        end
        ST_CMP: begin
          if (!used[idx] && (!have_best || rd_less)) begin
            best_b <= rd_b; best_e <= rd_e; best_idx <= idx; have_best <= 1'b1;
          end
          idx <= last_scan ? '0 : idx + 1'b1;
        end
        ST_MERGE: begin
          used[best_idx] <= 1'b1;
          have_best <= 1'b0;
          picked <= picked + 1'b1;
          if (picked == '0) begin
            cb <= best_b; ce <= best_e;
          end else if (join_ok) begin
            if (best_e > ce) ce <= best_e;
          end else begin
            // close the current run; the previous pending result goes out
            if (pend_v) result <= pend;
            pend   <= '{list, cb, ce, 1'b1, overflow_flag, 1'b0};
            pend_v <= 1'b1;
            cb <= best_b; ce <= best_e;
          end
        end
        ST_TAIL: begin
          if (pend_v) result <= pend;
          pend   <= '{list, cb, ce, 1'b1, overflow_flag, 1'b0};
          pend_v <= 1'b1;
          list   <= 1'b1;
        end
        ST_FINAL: begin
          // final result carries last_window; empty run gets a blank answer
          if (pend_v) result <= '{pend.list_reverse_mate, pend.window_begin,
                                  pend.window_end, 1'b1, overflow_flag, 1'b1};
          else result <= '{1'b0, '0, '0, 1'b0, overflow_flag, 1'b1};
          pend_v <= 1'b0;
          fwd_cnt <= '0; rev_cnt <= '0; overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    fwd_cnt <= CNT_BITS'(MAX_WINDOWS) && rev_cnt <= CNT_BITS'(MAX_WINDOWS))
    else $error("window count past capacity");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last_window |-> busy)
    else $error("non-final result after run closed");

  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    done && result.last_window |-> !busy && fwd_cnt == '0 && rev_cnt == '0
      && !overflow_flag)
    else $error("run not cleared at final result");

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

endmodule
`default_nettype wire

>>> tb/awbm_window_checker.sv
// ----------------------------------------------------------------------------
// awbm_window_checker - scoreboard for the amplicon window builder
// Watches hit, config and result channels, predicts merged windows, compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module awbm_window_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          busy,
  input  awbm_pkg::hit_req_t           hit,
  input  wire                          done,
  input  awbm_pkg::window_t            result,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire [awbm_pkg::REG_BITS-1:0] cfg_index,
  input  wire [awbm_pkg::POS_BITS-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending_windows
);
  import awbm_pkg::*;

  localparam logic [40:0] POS_TOP = 41'h0FF_FFFF_FFFF;

  logic [5:0] anchor_len, mate_len;
  pos_t ref_size, amp_min, amp_max;
  pos_t fwd_lo[$], fwd_hi[$], rev_lo[$], rev_hi[$];
  logic overflow_seen;
  window_t expected_windows[$];

  function automatic pos_t add_sat(pos_t a, logic [40:0] b);
    logic [41:0] s;
    s = a + b;
    return (s > POS_TOP) ? pos_t'(POS_TOP) : pos_t'(s);
  endfunction

  // sort by begin then end, merge overlapping/adjacent, queue results
  task automatic merge_list(ref pos_t lo[$], ref pos_t hi[$], input logic rev);
    pos_t b, e, cb, ce;
    int j;
    window_t w;
    for (int i = 1; i < lo.size(); i++) begin
      b = lo[i]; e = hi[i]; j = i;
      while (j > 0 && (lo[j-1] > b || (lo[j-1] == b && hi[j-1] > e))) begin
        lo[j] = lo[j-1]; hi[j] = hi[j-1]; j--;
      end
      lo[j] = b; hi[j] = e;
    end
    if (lo.size() == 0) return;
    cb = lo[0]; ce = hi[0];
    w = '0;
    w.list_reverse_mate = rev;
    w.window_valid = 1'b1;
    w.overflow = overflow_seen;
    for (int i = 1; i < lo.size(); i++) begin
      if ({1'b0, lo[i]} <= ((ce == pos_t'(POS_TOP)) ? {1'b0, ce} : {1'b0, ce} + 41'd1)) begin
        if (hi[i] > ce) ce = hi[i];
      end else begin
        w.window_begin = cb; w.window_end = ce;
        expected_windows = {expected_windows, w};
        cb = lo[i]; ce = hi[i];
      end
    end
    w.window_begin = cb; w.window_end = ce;
    expected_windows = {expected_windows, w};
    lo.delete(); hi.delete();
  endtask

  task automatic store(ref pos_t lo[$], ref pos_t hi[$], input pos_t l, input pos_t h);
    if (lo.size() >= MAX_WINDOWS) overflow_seen = 1'b1;
    else begin
      lo = {lo, l}; hi = {hi, h};
    end
  endtask

  task automatic predict_hit(hit_req_t h);
    pos_t p, lo, hi, top, aend;
    window_t w;
    p = h.hit_position;
    if (h.hit_valid && !h.hit_reverse) begin
      // reverse mate downstream of a forward anchor
      if (!(amp_max < mate_len || ref_size < mate_len)) begin
        top = ref_size - mate_len;
        lo = add_sat(p, anchor_len);
        if (amp_min > mate_len && add_sat(p, amp_min - mate_len) > lo)
          lo = add_sat(p, amp_min - mate_len);
        hi = add_sat(p, amp_max - mate_len);
        if (top < hi) hi = top;
        if (lo <= hi) store(rev_lo, rev_hi, lo, hi);
      end
    end else if (h.hit_valid) begin
      // forward mate upstream of a reverse anchor, no overlap with it
      if (!(ref_size < mate_len || p < mate_len)) begin
        aend = add_sat(p, anchor_len);
        if (aend >= amp_min) begin
          lo = (aend >= amp_max) ? aend - amp_max : '0;
          hi = aend - amp_min;
          if (p - mate_len < hi) hi = p - mate_len;
          if (ref_size - mate_len < hi) hi = ref_size - mate_len;
          if (lo <= hi) store(fwd_lo, fwd_hi, lo, hi);
        end
      end
    end
    if (h.last_hit) begin
      merge_list(fwd_lo, fwd_hi, 1'b0);
      merge_list(rev_lo, rev_hi, 1'b1);
      if (expected_windows.size() == 0) begin
        w = '0;
        w.overflow = overflow_seen;
        expected_windows = {expected_windows, w};
      end
      w = expected_windows.pop_back();
      w.last_window = 1'b1;
      expected_windows = {expected_windows, w};
      overflow_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    window_t want;
    if (rst) begin
      anchor_len <= 6'd20; mate_len <= 6'd20;
      ref_size <= '0; amp_min <= 40'd1; amp_max <= 40'd1000;
      fwd_lo.delete(); fwd_hi.delete(); rev_lo.delete(); rev_hi.delete();
      overflow_seen = 1'b0;
      expected_windows.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ANC_LEN:   anchor_len <= cfg_data[5:0];
          REG_MATE_LEN:  mate_len <= cfg_data[5:0];
          REG_REF_BASES: ref_size <= cfg_data;
          REG_AMP_MIN:   amp_min <= cfg_data;
          REG_AMP_MAX:   amp_max <= cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (expected_windows.size() == 0) begin
          $error("unexpected window result %h", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_windows.pop_front();
          if (result !== want) begin
            fail_count <= fail_count + 1;
            if (result.list_reverse_mate !== want.list_reverse_mate)
              $error("list_reverse_mate exp %0d got %0d", want.list_reverse_mate,
                     result.list_reverse_mate);
            if (result.window_begin !== want.window_begin)
              $error("window_begin exp %0d got %0d", want.window_begin, result.window_begin);
            if (result.window_end !== want.window_end)
              $error("window_end exp %0d got %0d", want.window_end, result.window_end);
            if (result.window_valid !== want.window_valid)
              $error("window_valid exp %0d got %0d", want.window_valid, result.window_valid);
            if (result.overflow !== want.overflow)
              $error("overflow exp %0d got %0d", want.overflow, result.overflow);
            if (result.last_window !== want.last_window)
              $error("last_window exp %0d got %0d", want.last_window, result.last_window);
          end
        end
      end
      if (start && !busy) predict_hit(hit);
    end
    pending_windows <= expected_windows.size();
  end
endmodule

>>> tb/tb_amplicon_window_build_merge.sv
// ----------------------------------------------------------------------------
// tb_amplicon_window_build_merge - top of the amplicon window builder bench
// Drives hit requests and register writes; checker scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_amplicon_window_build_merge;
  import awbm_pkg::*;

  // Worst case idle stretch: a merge of two 32-window lists plus random gaps;
  // anything past this means the block hung.
  localparam int STALL_LIMIT = 20000;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  hit_req_t hit;
  window_t result;
  logic [REG_BITS-1:0] cfg_index;
  pos_t cfg_data;
  int fail_count, pending_windows;
  int quiet_cycles;

  amplicon_window_build_merge u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .hit(hit),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  awbm_window_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .hit(hit), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending_windows(pending_windows)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: counts cycles with no accepted request, register write or result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One request: random gap, then hold start until the block takes it.
  task automatic send_hit(logic v, pos_t p, logic rev, logic last);
    repeat ($urandom_range(0, 19)) @(posedge clk);
    start <= 1'b1;
    hit <= '{hit_valid: v, hit_position: p, hit_reverse: rev, last_hit: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    hit <= '{hit_valid: 1'($urandom_range(0, 1)),
             hit_position: pos_t'({$urandom, $urandom}),
             hit_reverse: 1'($urandom_range(0, 1)),
             last_hit: 1'($urandom_range(0, 1))};
  endtask

  task automatic write_reg(reg_index_t idx, pos_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain: wait until the block is idle and every expected window is in.
  task automatic drain;
    @(posedge clk);
    while (busy || pending_windows != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(logic [5:0] al, logic [5:0] ml, pos_t rs, pos_t mn, pos_t mx);
    write_reg(REG_ANC_LEN, pos_t'(al));
    write_reg(REG_MATE_LEN, pos_t'(ml));
    write_reg(REG_REF_BASES, rs);
    write_reg(REG_AMP_MIN, mn);
    write_reg(REG_AMP_MAX, mx);
  endtask

  // Random position: mostly within or just past the reference, sometimes anywhere.
  function automatic pos_t pick_pos(pos_t rs);
    if ($urandom_range(0, 9) == 0) return pos_t'({$urandom, $urandom});
    if (rs == 0) return pos_t'($urandom_range(0, 4000));
    return pos_t'({$urandom, $urandom} % (rs + 64));
  endfunction

  initial begin
    pos_t rs;
    int run_len;
    start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0; hit = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: reference size 0 drops every window, empty answer.
    send_hit(1'b1, 40'd500, 1'b0, 1'b0);
    send_hit(1'b1, 40'd500, 1'b1, 1'b1);
    drain();

    // Directed: both strands, extremes, invalid hit ending a run, overlap merge.
    set_regs(6'd20, 6'd20, 40'd100000, 40'd100, 40'd1000);
    send_hit(1'b1, 40'd0, 1'b0, 1'b0);
    send_hit(1'b1, 40'd0, 1'b1, 1'b0);        // below mate length: no window
    send_hit(1'b1, 40'd5000, 1'b1, 1'b0);
    send_hit(1'b1, 40'd5001, 1'b1, 1'b0);     // overlaps previous
    send_hit(1'b1, 40'd3000, 1'b0, 1'b0);
    send_hit(1'b1, 40'd3981, 1'b0, 1'b0);     // just past previous: a gap, no merge
    send_hit(1'b1, 40'hFF_FFFF_FFFF, 1'b0, 1'b0);
    send_hit(1'b1, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
    send_hit(1'b0, 40'hFF_FFFF_FFFF, 1'b1, 1'b1);
    drain();
    // Saturation: huge reference and amplicon limits; odd registers.
    set_regs(6'd63, 6'd0, 40'hFF_FFFF_FFFF, 40'd0, 40'hFF_FFFF_FFFF);
    send_hit(1'b1, 40'hFF_FFFF_FFF0, 1'b0, 1'b0);
    send_hit(1'b1, 40'hFF_FFFF_FFF0, 1'b1, 1'b0);
    send_hit(1'b1, 40'd0, 1'b1, 1'b0);
    send_hit(1'b1, 40'd7, 1'b0, 1'b1);
    drain();
    set_regs(6'd35, 6'd35, 40'd50000, 40'd2000, 40'd10);   // min above max
    send_hit(1'b1, 40'd9000, 1'b0, 1'b0);
    send_hit(1'b1, 40'd9000, 1'b1, 1'b1);
    drain();
    // Overflow: 34 forward hits into a 32-entry list.
    set_regs(6'd18, 6'd18, 40'd1000000, 40'd1, 40'd300);
    for (int i = 0; i < 34; i++)
      send_hit(1'b1, pos_t'(i * 1000), 1'b0, i == 33);
    drain();

    // Random runs under several register settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: rs = 40'd20000;
        1: rs = 40'd3000;
        2: rs = 40'hFF_FFFF_FFFF;
        3: rs = 40'd0;
        default: rs = pos_t'($urandom_range(100, 200000));
      endcase
      set_regs(6'($urandom_range(18, 35)), 6'($urandom_range(18, 35)), rs,
               pos_t'($urandom_range(1, 400)), pos_t'($urandom_range(400, 3000)));
      for (int r = 0; r < 8; r++) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++)
          send_hit($urandom_range(0, 7) != 0, pick_pos(rs), 1'($urandom_range(0, 1)),
                   i == run_len - 1);
      end
      drain();
    end

    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> sim.f
hdl/awbm_pkg.sv
hdl/amplicon_window_build_merge.sv
tb/awbm_window_checker.sv
tb/tb_amplicon_window_build_merge.sv
